### sv/brs_pkg.sv
`timescale 1ns / 1ps

package brs_pkg;

    // Default duty resolution, Q0.DUTY_BITS
    localparam int DUTY_BITS_DEF = 16;

    // Converter regions
    localparam logic [1:0] RG_BUCK  = 2'd0;
    localparam logic [1:0] RG_MIXED = 2'd1;
    localparam logic [1:0] RG_BOOST = 2'd2;

    // Item kinds carried on the input side-band
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_REGULATE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SETPOINT      = 2'd0;
    localparam logic [1:0] CFG_BUCK_MARGIN   = 2'd1;
    localparam logic [1:0] CFG_BOOST_MARGIN  = 2'd2;
    localparam logic [1:0] CFG_HIT_THRESHOLD = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] SETPOINT_RESET  = 16'd10000;
    localparam logic [12:0] MARGIN_RESET    = 13'd800;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1000;

    // At or below this voltage the buck start duty is not computed
    localparam logic [15:0] MV_FLOOR = 16'd1000;

    typedef struct packed {
        logic [15:0] setpoint_mv;
        logic [12:0] buck_margin_mv;
        logic [12:0] boost_margin_mv;
        logic [15:0] hit_threshold;
    } cfg_t;

    // Request to the divider: num * 2^DUTY_BITS / den
    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } div_req_t;

    // A fraction given in thousandths, rounded to the nearest code
    function automatic longint unsigned permille(input int unsigned x,
                                                 input int unsigned bits);
        return ((longint'(x) << bits) + 64'd500) / 64'd1000;
    endfunction

endpackage

### sv/brs_divider.sv
`timescale 1ns / 1ps

module brs_divider #(
    parameter int DUTY_BITS = brs_pkg::DUTY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  brs_pkg::div_req_t    req,
    output logic                 done,
    output logic [DUTY_BITS-1:0] quotient
);
    import brs_pkg::*;

    localparam int CNT_W = $clog2(DUTY_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [16:0]          rem_reg, rem_next;
    logic [DUTY_BITS-1:0] q_reg, q_next;
    logic [16:0]          rem_shift;
    logic                 fits;

    // One restoring step per cycle; the numerator is below the divisor, so
    // the quotient fits in DUTY_BITS bits.
    assign rem_shift = {rem_reg[15:0], 1'b0};
    assign fits      = rem_shift >= {1'b0, req.den};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DUTY_BITS);
            rem_next  = {1'b0, req.num};
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_shift - {1'b0, req.den}) : rem_shift;
            q_next   = {q_reg[DUTY_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### sv/brs_core.sv
`timescale 1ns / 1ps

module brs_core #(
    parameter int DUTY_BITS = brs_pkg::DUTY_BITS_DEF,
    parameter int OUT_W     = ((6 + 3 * DUTY_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  brs_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_command,
    input  logic [15:0]          in_vin_mv,
    input  logic [DUTY_BITS-1:0] in_duty_request,
    output brs_pkg::div_req_t    div_req,
    input  logic                 div_done,
    input  logic [DUTY_BITS-1:0] div_quotient,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_W-1:0]     out_data
);
    import brs_pkg::*;

    localparam logic [DUTY_BITS-1:0] D_MIN_ALL     = DUTY_BITS'(permille(1, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_MAX_ALL     = DUTY_BITS'(permille(999, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_BUCK_MAX    = DUTY_BITS'(permille(950, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_MIX_MAX     = DUTY_BITS'(permille(450, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_BOOST_MIN   = DUTY_BITS'(permille(50, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_START_LO    = DUTY_BITS'(permille(150, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_START_HI    = DUTY_BITS'(permille(300, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_MIX_START   = DUTY_BITS'(permille(200, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_BOOST_START = DUTY_BITS'(permille(120, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_MIX_TRIGGER = DUTY_BITS'(permille(600, DUTY_BITS));
    localparam logic [DUTY_BITS-1:0] D_HALF        = DUTY_BITS'(permille(500, DUTY_BITS));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    function automatic logic [DUTY_BITS-1:0] start_duty_of(input logic [1:0] rg);
        logic [DUTY_BITS-1:0] d;
        case (rg)
            RG_BUCK:  d = D_START_LO;
            RG_BOOST: d = D_BOOST_START;
            default:  d = D_MIX_START;
        endcase
        return d;
    endfunction

    // Saturating up/down hit counter
    function automatic logic [15:0] count(input logic [15:0] c, input logic hit,
                                          input logic [15:0] thr);
        logic [15:0] n;
        if (hit) n = (c < thr) ? c + 16'd1 : c;
        else     n = (c != 16'd0) ? c - 16'd1 : c;
        return n;
    endfunction

    logic [1:0]           state_reg, state_next;
    logic                 cmd_reg;
    logic [15:0]          vin_reg;
    logic [DUTY_BITS-1:0] req_reg;
    logic                 use_div_reg, use_div_next;
    logic [1:0]           region_reg, region_next;
    logic [15:0]          top_hits_reg, top_hits_next;
    logic [15:0]          bot_hits_reg, bot_hits_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    logic                 accept, out_free, load;
    logic                 go_buck, go_boost;
    logic [1:0]           start_rg;
    logic [DUTY_BITS-1:0] buck_raw, buck_duty;
    logic [DUTY_BITS-1:0] lo, hi;
    logic                 top, bottom, sw, reload;
    logic [15:0]          top_cnt, bot_cnt;
    logic [1:0]           rg;
    logic [DUTY_BITS-1:0] duty, applied, trig;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || out_ready;
    assign load     = (state_reg == ST_OUT) && out_free;

    // Region choice of a start item
    assign go_buck  = {1'b0, vin_reg} > ({1'b0, cfg.setpoint_mv} + 17'(cfg.buck_margin_mv));
    assign go_boost = ({1'b0, vin_reg} + 17'(cfg.boost_margin_mv)) < {1'b0, cfg.setpoint_mv};
    assign start_rg = go_buck ? RG_BUCK : (go_boost ? RG_BOOST : RG_MIXED);

    assign div_req.start = (state_reg == ST_EVAL) && use_div_next;
    assign div_req.num   = cfg.setpoint_mv;
    assign div_req.den   = vin_reg;

    // Buck start duty, clamped to its start window
    always_comb begin
        buck_raw  = use_div_reg ? div_quotient : D_START_LO;
        buck_duty = buck_raw;
        if (buck_raw < D_START_LO) buck_duty = D_START_LO;
        if (buck_raw > D_START_HI) buck_duty = D_START_HI;
    end

    // Result of the held item
    always_comb begin
        lo      = (region_reg == RG_BOOST) ? D_BOOST_MIN : D_MIN_ALL;
        hi      = (region_reg == RG_MIXED) ? D_MIX_MAX : D_BUCK_MAX;
        top     = 1'b0;
        bottom  = 1'b0;
        sw      = 1'b0;
        reload  = 1'b0;
        rg      = region_reg;
        duty    = req_reg;
        top_cnt = 16'd0;
        bot_cnt = 16'd0;
        if (cmd_reg == CMD_START) begin
            rg     = start_rg;
            duty   = go_buck ? buck_duty : start_duty_of(start_rg);
            reload = 1'b1;
            sw     = (start_rg != region_reg);
        end else begin
            if (req_reg >= hi) begin
                duty = hi;
                top  = 1'b1;
            end else if (req_reg <= lo) begin
                duty   = lo;
                bottom = 1'b1;
            end
            top_cnt = count(top_hits_reg, top, cfg.hit_threshold);
            bot_cnt = count(bot_hits_reg, bottom, cfg.hit_threshold);
            case (region_reg)
                RG_BUCK: begin
                    if (top_cnt >= cfg.hit_threshold) begin
                        rg = RG_MIXED;
                        sw = 1'b1;
                    end
                end
                RG_MIXED: begin
                    if (top_cnt >= cfg.hit_threshold) begin
                        rg = RG_BOOST;
                        sw = 1'b1;
                    end else if (bot_cnt >= cfg.hit_threshold) begin
                        rg = RG_BUCK;
                        sw = 1'b1;
                    end
                end
                default: begin
                    if (bot_cnt >= cfg.hit_threshold) begin
                        rg = RG_MIXED;
                        sw = 1'b1;
                    end
                end
            endcase
            if (sw) begin
                top_cnt = 16'd0;
                bot_cnt = 16'd0;
                duty    = start_duty_of(rg);
                reload  = 1'b1;
            end
        end
    end

    // Drive stage: global clamp and ADC trigger placement
    always_comb begin
        applied = duty;
        if (duty < D_MIN_ALL) applied = D_MIN_ALL;
        if (duty > D_MAX_ALL) applied = D_MAX_ALL;
        if (rg == RG_MIXED)       trig = D_MIX_TRIGGER;
        else if (applied > D_HALF) trig = applied >> 1;
        else                       trig = {1'b1, applied[DUTY_BITS-1:1]};
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        use_div_next  = use_div_reg;
        region_next   = region_reg;
        top_hits_next = top_hits_reg;
        bot_hits_next = bot_hits_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                use_div_next = (cmd_reg == CMD_START) && go_buck &&
                               (vin_reg > MV_FLOOR) && (cfg.setpoint_mv > MV_FLOOR);
                state_next   = use_div_next ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            default: begin
                if (out_free) begin
                    region_next   = rg;
                    top_hits_next = top_cnt;
                    bot_hits_next = bot_cnt;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    // Output register: fields from the lowest bit up
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({(reload ? duty : {DUTY_BITS{1'b0}}), reload, bottom,
                                   top, sw, trig, applied, rg});
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            use_div_reg  <= 1'b0;
            region_reg   <= RG_BUCK;
            top_hits_reg <= 16'd0;
            bot_hits_reg <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            use_div_reg  <= use_div_next;
            region_reg   <= region_next;
            top_hits_reg <= top_hits_next;
            bot_hits_reg <= bot_hits_next;
            m_valid_reg  <= m_valid_next;
        end
        if (accept) begin
            cmd_reg <= in_command;
            vin_reg <= in_vin_mv;
            req_reg <= in_duty_request;
        end
        m_data_reg <= m_data_next;
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

### sv/buck_boost_region_selector.sv
`timescale 1ns / 1ps

// Channel   | Direction | Contents
// ----------+-----------+---------------------------------------------------
// s_        | in        | tuser: command; tdata: vin_mv, duty_request
// m_        | out       | tdata: region .. reload_duty, one transfer per item
// cfg_      | in        | register index and write data
//
// A regulate item or a non-buck start item passes through the evaluate and
// output states until the block is ready again; a buck start item whose duty
// is computed also waits in the divide state for the one-bit-per-cycle divider.
// Reset (aresetn low at a clock edge) restores the configuration defaults,
// buck region and cleared hit counters.
// A result waiting on m_tready holds the output register; the next item is
// still taken and is held back only at its own result.
module buck_boost_region_selector #(
    parameter int DUTY_BITS = brs_pkg::DUTY_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] vin_mv, then duty_request
    input  logic [((16 + DUTY_BITS + 7) / 8) * 8-1:0] s_tdata,
    // [0] command
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // region, applied_duty, adc_trigger, region_switched, top_limit_hit,
    // bottom_limit_hit, reload_regulator, reload_duty, zero fill
    output logic [((6 + 3 * DUTY_BITS + 7) / 8) * 8-1:0] m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [15:0]                            cfg_data
);
    import brs_pkg::*;

    localparam int OUT_W = ((6 + 3 * DUTY_BITS + 7) / 8) * 8;

    cfg_t                 cfg_reg, cfg_next;
    div_req_t             div_req;
    logic                 div_done;
    logic [DUTY_BITS-1:0] div_quotient;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SETPOINT:     cfg_next.setpoint_mv     = cfg_data;
                CFG_BUCK_MARGIN:  cfg_next.buck_margin_mv  = cfg_data[12:0];
                CFG_BOOST_MARGIN: cfg_next.boost_margin_mv = cfg_data[12:0];
                default:          cfg_next.hit_threshold   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint_mv     <= SETPOINT_RESET;
            cfg_reg.buck_margin_mv  <= MARGIN_RESET;
            cfg_reg.boost_margin_mv <= MARGIN_RESET;
            cfg_reg.hit_threshold   <= THRESHOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    brs_divider #(
        .DUTY_BITS (DUTY_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    brs_core #(
        .DUTY_BITS (DUTY_BITS),
        .OUT_W     (OUT_W)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tuser),
        .in_vin_mv       (s_tdata[15:0]),
        .in_duty_request (s_tdata[16 +: DUTY_BITS]),
        .div_req         (div_req),
        .div_done        (div_done),
        .div_quotient    (div_quotient),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (m_tdata)
    );

endmodule
